[sv/conductivity_median_ema_compensate_defines.svh]
// Assertion macros for the conductivity front end.
// Included by files that carry concurrent assertions; needs no other file.
`ifndef CONDUCTIVITY_MEDIAN_EMA_COMPENSATE_DEFINES_SVH
`define CONDUCTIVITY_MEDIAN_EMA_COMPENSATE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define CMEC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define CMEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMEC_ASSERT(lbl, clk, rstn, prop, msg)
`define CMEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/cmec_pkg.sv]
// Shared types and constants of the conductivity front end.
// Used by the interfaces, the serial arithmetic unit and the top level.
package cmec_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_EMA_WEIGHT,
    CFG_CELL_CONSTANT,
    CFG_TEMP_COEFF,
    CFG_TDS_FACTOR
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 20;

  // Item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [9:0]         raw_sample;
    logic [12:0]        supply_mv;
    logic signed [15:0] temperature;
  } in_beat_t;

  typedef struct packed {
    logic [17:0] ec_raw_us;
    logic [19:0] ec25_us;
    logic [19:0] tds_ppm;
  } out_beat_t;

  // Request to and response from the serial multiply / divide unit
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] a;
    logic [31:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } arith_rsp_t;

endpackage

[sv/cmec_stream_if.sv]
// Valid/ready channels of the conductivity front end.
// Depends on cmec_pkg for the beat types.
interface cmec_in_if;
  import cmec_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cmec_out_if;
  import cmec_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/cmec_serial_alu.sv]
// Shared serial arithmetic: shift-add multiply and restoring divide.
// Depends on cmec_pkg for the request and response structs.
module cmec_serial_alu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmec_pkg::arith_req_t req_i,
  output cmec_pkg::arith_rsp_t rsp_o
);
  import cmec_pkg::*;

  localparam int unsigned DIV_STEPS = 64;

  logic        busy_q, busy_d;
  logic        div_q, div_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] sh_q, sh_d;
  logic [31:0] dv_q, dv_d;

  logic [32:0] rem_ext;
  logic [32:0] rem_sub;
  logic        ge;

  // Trial subtract for one quotient bit
  assign rem_ext = {acc_q[31:0], sh_q[63]};
  assign rem_sub = rem_ext - {1'b0, dv_q};
  assign ge      = (rem_ext >= {1'b0, dv_q});

  // Advance one multiplier bit or one quotient bit per cycle while busy
  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    dv_d   = dv_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      div_d  = req_i.is_div;
      cnt_d  = '0;
      acc_d  = '0;
      sh_d   = req_i.a;
      dv_d   = req_i.b;
    end else if (busy_q) begin
      if (div_q) begin
        acc_d = {32'd0, ge ? rem_sub[31:0] : rem_ext[31:0]};
        sh_d  = {sh_q[62:0], ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else if (dv_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (dv_q[0]) begin
          acc_d = acc_q + sh_q;
        end
        sh_d = {sh_q[62:0], 1'b0};
        dv_d = {1'b0, dv_q[31:1]};
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    dv_q  <= dv_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = div_q ? sh_q : acc_q;

endmodule

[sv/conductivity_median_ema_compensate.sv]
// Conductivity front end: median window, exponential average, compensation.
// Depends on cmec_pkg, cmec_stream_if, cmec_serial_alu and the defines header.
//
// Usage:
//   in_i carries items: op 0 stores a sample and updates the averaged
//   voltage, op 1 requests a report. out_o carries one result per report,
//   none per sample. The cfg_* port writes a register, and is to be used
//   only while the block is idle.
// Timing:
//   One item at a time; in_i.ready is high only while idle. For a sample,
//   the median walk compares every filled pair once through a two-port
//   ring read, then the shared serial unit runs one multiply, one 64-step
//   divide and, once the average has started, two multiplies of up to 20
//   steps each. For a report the serial unit runs seven multiplies of up
//   to 20 steps and three 64-step divides.
// Reset:
//   Registers take their default values, the window is empty and the
//   average is not started; no result is pending.
// Stall:
//   A result waits in the output register; the next item is accepted
//   meanwhile, and a new report holds before its result until it drains.
`include "conductivity_median_ema_compensate_defines.svh"

module conductivity_median_ema_compensate #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cmec_in_if.sink                             in_i,
  cmec_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  cmec_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [cmec_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cmec_pkg::*;

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FW = $clog2(WINDOW + 1);

  localparam logic [31:0] VOLT_DIV   = 32'd2046000;
  localparam logic [63:0] VOLT_HALF  = 64'd1023000;
  localparam logic [63:0] ROUND_Q16  = 64'd32768;
  localparam logic [63:0] ROUND_Q8   = 64'd128;
  localparam logic [31:0] POLY_A     = 32'd13342;
  localparam logic [31:0] POLY_B     = 32'd25586;
  localparam logic [63:0] POLY_C_Q32 = 64'd85739 << 32;
  localparam logic [31:0] EC8_DIV    = 32'd1677721600;
  localparam logic [63:0] EC8_HALF   = 64'd838860800;
  localparam logic [63:0] COMP_ONE   = 64'd16777216;
  localparam logic [63:0] T25_Q8     = 64'd6400;
  localparam logic [31:0] TDS_DIV    = 32'd256000;
  localparam logic [63:0] TDS_HALF   = 64'd128000;
  localparam logic [17:0] EC_RAW_MAX = 18'h3FFFF;
  localparam logic [19:0] OUT20_MAX  = 20'hFFFFF;
  localparam logic [16:0] W_ONE      = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MED,
    ST_MED_END,
    ST_S_PROD,
    ST_S_DIV,
    ST_S_EMA_A,
    ST_S_EMA_B,
    ST_R_SQ,
    ST_R_QUAD,
    ST_R_LIN,
    ST_R_POLY,
    ST_R_CELL,
    ST_R_EC8,
    ST_R_COMP,
    ST_R_EC25,
    ST_R_TDSM,
    ST_R_TDSD,
    ST_R_OUT
  } state_e;

  function automatic logic [17:0] sat18(logic [63:0] v);
    return (v > {46'd0, EC_RAW_MAX}) ? EC_RAW_MAX : v[17:0];
  endfunction

  function automatic logic [19:0] sat20(logic [63:0] v);
    return (v > {44'd0, OUT20_MAX}) ? OUT20_MAX : v[19:0];
  endfunction

  // Control state
  state_e         state_q, state_d;
  logic           launched_q, launched_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d;
  logic [IW-1:0]  rank_q, rank_d;
  logic [IW-1:0]  slot_q, slot_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           started_q, started_d;
  logic [19:0]    filt_q, filt_d;
  logic           out_valid_q, out_valid_d;
  logic [15:0]    w_q, w_d;
  logic [19:0]    k_q, k_d;
  logic [13:0]    alpha_q, alpha_d;
  logic [9:0]     tds_q, tds_d;
  logic           p_v_q, p_v_d;

  // Datapath
  logic [9:0]     ring_q [WINDOW];
  logic [9:0]     rd_a_q, rd_b_q;
  logic [IW-1:0]  p_i_q, p_j_q;
  logic           p_last_q, p_last_d;
  logic [12:0]    mv_q, mv_d;
  logic [15:0]    t_q, t_d;
  logic [9:0]     lo_q, lo_d, hi_q, hi_d;
  logic [63:0]    x_q, x_d;
  logic [63:0]    y_q, y_d;
  logic [31:0]    comp_q, comp_d;
  logic [17:0]    er_q, er_d;
  logic [19:0]    e25_q, e25_d;
  logic [19:0]    tdso_q, tdso_d;
  out_beat_t      out_data_q, out_data_d;

  arith_req_t     req;
  arith_rsp_t     rsp;

  logic           in_acc, out_acc, ring_we;
  logic [IW-1:0]  n_last, lo_tgt, hi_tgt, rank_inc;
  logic           lt;
  logic [10:0]    m2;
  logic [63:0]    comp_sum;
  logic [31:0]    comp_new;
  logic           calc_st;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign ring_we    = in_acc && (in_i.data.op == OP_SAMPLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Median ranking of one candidate against one other entry
  assign n_last   = IW'(fill_q - FW'(1));
  assign lo_tgt   = IW'((fill_q - FW'(1)) >> 1);
  assign hi_tgt   = IW'(fill_q >> 1);
  assign lt       = (rd_b_q < rd_a_q) || ((rd_b_q == rd_a_q) && (p_j_q < p_i_q));
  assign rank_inc = rank_q + IW'(lt);
  assign m2       = {1'b0, lo_q} + {1'b0, hi_q};

  // Positive compensation factor, else one
  assign comp_sum = COMP_ONE + rsp.result;
  assign comp_new = (comp_sum[63] || comp_sum == '0) ? COMP_ONE[31:0] : comp_sum[31:0];

  assign calc_st = !((state_q == ST_IDLE) || (state_q == ST_MED) ||
                     (state_q == ST_MED_END) || (state_q == ST_R_OUT));

  // Drive the serial unit from the current step
  always_comb begin
    req.start  = calc_st && !launched_q;
    req.is_div = 1'b0;
    req.a      = x_q;
    req.b      = '0;
    case (state_q)
      ST_S_PROD: begin
        req.a = {53'd0, m2};
        req.b = {19'd0, mv_q};
      end
      ST_S_DIV: begin
        req.is_div = 1'b1;
        req.b      = VOLT_DIV;
      end
      ST_S_EMA_A: begin
        req.a = {44'd0, x_q[19:0]};
        req.b = {16'd0, w_q};
      end
      ST_S_EMA_B: begin
        req.a = {44'd0, filt_q};
        req.b = {15'd0, W_ONE - {1'b0, w_q}};
      end
      ST_R_SQ: begin
        req.a = {44'd0, filt_q};
        req.b = {12'd0, filt_q};
      end
      ST_R_QUAD: req.b = POLY_A;
      ST_R_LIN: begin
        req.a = {44'd0, filt_q};
        req.b = POLY_B;
      end
      ST_R_POLY: req.b = {12'd0, filt_q};
      ST_R_CELL: req.b = {12'd0, k_q};
      ST_R_EC8: begin
        req.is_div = 1'b1;
        req.b      = EC8_DIV;
      end
      ST_R_COMP: begin
        req.a = {{48{t_q[15]}}, t_q} - T25_Q8;
        req.b = {18'd0, alpha_q};
      end
      ST_R_EC25: begin
        req.is_div = 1'b1;
        req.b      = comp_q;
      end
      ST_R_TDSM: req.b = {22'd0, tds_q};
      ST_R_TDSD: begin
        req.is_div = 1'b1;
        req.b      = TDS_DIV;
      end
      default: req.start = 1'b0;
    endcase
  end

  // Sequence the items
  always_comb begin
    state_d     = state_q;
    launched_d  = launched_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    started_d   = started_q;
    filt_d      = filt_q;
    out_valid_d = out_valid_q;
    w_d         = w_q;
    k_d         = k_q;
    alpha_d     = alpha_q;
    tds_d       = tds_q;
    p_v_d       = (state_q == ST_MED);
    p_last_d    = (j_q == n_last);
    mv_d        = mv_q;
    t_d         = t_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    x_d         = x_q;
    y_d         = y_q;
    comp_d      = comp_q;
    er_d        = er_q;
    e25_d       = e25_q;
    tdso_d      = tdso_q;
    out_data_d  = out_data_q;

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EMA_WEIGHT:    w_d     = cfg_data_i[15:0];
        CFG_CELL_CONSTANT: k_d     = cfg_data_i[19:0];
        CFG_TEMP_COEFF:    alpha_d = cfg_data_i[13:0];
        CFG_TDS_FACTOR:    tds_d   = cfg_data_i[9:0];
        default: ;
      endcase
    end

    // Drop a delivered result
    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    if (req.start) begin
      launched_d = 1'b1;
    end
    if (rsp.done) begin
      launched_d = 1'b0;
    end

    // Accumulate the rank of the candidate entry
    if (p_v_q) begin
      if (p_last_q) begin
        if (rank_inc == lo_tgt) lo_d = rd_a_q;
        if (rank_inc == hi_tgt) hi_d = rd_a_q;
        rank_d = '0;
      end else begin
        rank_d = rank_inc;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.op == OP_SAMPLE) begin
            slot_d = (slot_q == IW'(WINDOW - 1)) ? '0 : slot_q + IW'(1);
            if (fill_q != FW'(WINDOW)) fill_d = fill_q + FW'(1);
            mv_d    = in_i.data.supply_mv;
            i_d     = '0;
            j_d     = '0;
            rank_d  = '0;
            state_d = ST_MED;
          end else begin
            t_d     = in_i.data.temperature;
            state_d = ST_R_SQ;
          end
        end
      end
      ST_MED: begin
        if (j_q == n_last) begin
          j_d = '0;
          if (i_q == n_last) state_d = ST_MED_END;
          else               i_d = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      ST_MED_END: state_d = ST_S_PROD;
      ST_S_PROD: if (rsp.done) begin
        x_d     = (rsp.result << 16) + VOLT_HALF;
        state_d = ST_S_DIV;
      end
      ST_S_DIV: if (rsp.done) begin
        x_d = rsp.result;
        if (!started_q) begin
          started_d = 1'b1;
          filt_d    = rsp.result[19:0];
          state_d   = ST_IDLE;
        end else begin
          state_d = ST_S_EMA_A;
        end
      end
      ST_S_EMA_A: if (rsp.done) begin
        x_d     = rsp.result;
        state_d = ST_S_EMA_B;
      end
      ST_S_EMA_B: if (rsp.done) begin
        filt_d  = 20'((x_q + rsp.result + ROUND_Q16) >> 16);
        state_d = ST_IDLE;
      end
      ST_R_SQ: if (rsp.done) begin
        x_d     = rsp.result;
        state_d = ST_R_QUAD;
      end
      ST_R_QUAD: if (rsp.done) begin
        x_d     = rsp.result + POLY_C_Q32;
        state_d = ST_R_LIN;
      end
      ST_R_LIN: if (rsp.done) begin
        x_d     = (x_q - (rsp.result << 16) + ROUND_Q16) >> 16;
        state_d = ST_R_POLY;
      end
      ST_R_POLY: if (rsp.done) begin
        x_d     = (rsp.result + ROUND_Q16) >> 16;
        state_d = ST_R_CELL;
      end
      ST_R_CELL: if (rsp.done) begin
        x_d     = rsp.result + EC8_HALF;
        state_d = ST_R_EC8;
      end
      ST_R_EC8: if (rsp.done) begin
        y_d     = rsp.result;
        er_d    = sat18((rsp.result + ROUND_Q8) >> 8);
        state_d = ST_R_COMP;
      end
      ST_R_COMP: if (rsp.done) begin
        comp_d  = comp_new;
        x_d     = (y_q << 24) + {33'd0, comp_new[31:1]};
        state_d = ST_R_EC25;
      end
      ST_R_EC25: if (rsp.done) begin
        x_d     = rsp.result;
        e25_d   = sat20((rsp.result + ROUND_Q8) >> 8);
        state_d = ST_R_TDSM;
      end
      ST_R_TDSM: if (rsp.done) begin
        x_d     = rsp.result + TDS_HALF;
        state_d = ST_R_TDSD;
      end
      ST_R_TDSD: if (rsp.done) begin
        tdso_d  = sat20(rsp.result);
        state_d = ST_R_OUT;
      end
      ST_R_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d          = 1'b1;
          out_data_d.ec_raw_us = er_q;
          out_data_d.ec25_us   = e25_q;
          out_data_d.tds_ppm   = tdso_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      started_q   <= 1'b0;
      filt_q      <= '0;
      out_valid_q <= 1'b0;
      w_q         <= 16'd19661;
      k_q         <= 20'd65536;
      alpha_q     <= 14'd1311;
      tds_q       <= 10'd500;
      p_v_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      i_q         <= i_d;
      j_q         <= j_d;
      rank_q      <= rank_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      started_q   <= started_d;
      filt_q      <= filt_d;
      out_valid_q <= out_valid_d;
      w_q         <= w_d;
      k_q         <= k_d;
      alpha_q     <= alpha_d;
      tds_q       <= tds_d;
      p_v_q       <= p_v_d;
    end
  end

  // Sample ring: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[slot_q] <= in_i.data.raw_sample;
    end
    rd_a_q <= ring_q[i_q];
    rd_b_q <= ring_q[j_q];
  end

  // Hold datapath values
  always_ff @(posedge clk_i) begin
    p_i_q      <= i_q;
    p_j_q      <= j_q;
    p_last_q   <= p_last_d;
    mv_q       <= mv_d;
    t_q        <= t_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    x_q        <= x_d;
    y_q        <= y_d;
    comp_q     <= comp_d;
    er_q       <= er_d;
    e25_q      <= e25_d;
    tdso_q     <= tdso_d;
    out_data_q <= out_data_d;
  end

  cmec_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Checks
  `CMEC_ASSERT(a_done_launched, clk_i, rst_ni, rsp.done |-> launched_q, "unit finished unrequested")
  `CMEC_ASSERT(a_acc_leaves_idle, clk_i, rst_ni, in_acc |=> (state_q != ST_IDLE), "accept kept idle")
  `CMEC_ASSERT(a_out_from_report, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_R_OUT), "result without report")
  `CMEC_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= FW'(WINDOW), "fill count beyond window")

endmodule
